/* sv/nrsh_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and control types for the nearest ray/segment hit block.
// No dependencies; every other file imports this package.

package nrsh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int T_W       = 32;

    // Multiplier operand: a 32-bit signed value or a zero-extended 32-bit t.
    localparam int MUL_W   = COORD_W + 1;
    localparam int ACC_W   = 2 * COORD_W + 2;
    localparam int DEN_W   = 2 * COORD_W;
    localparam int REM_W   = DEN_W + 1;
    // The segment parameter u lies in [0, 2^FRAC_BITS].
    localparam int U_W        = FRAC_BITS + 1;
    localparam int U_MUL_BITS = FRAC_BITS + 2;
    localparam int NUMER_W    = COORD_W + FRAC_BITS + 1;
    localparam int MAG_W      = COORD_W + FRAC_BITS;
    localparam int CNT_W      = $clog2(MUL_W + 1);

    localparam logic [T_W-1:0] T_MAX = '1;

    localparam logic signed [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};
    localparam logic signed [COORD_W-1:0] INT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] INT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } t_mac_req;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_req;

endpackage

/* sv/nrsh_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels of the nearest ray/segment hit block: segment words in,
// hit words out. Depends on nrsh_pkg.

interface nrsh_seg_if import nrsh_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] ray_origin_x;
    logic signed [COORD_W-1:0] ray_origin_y;
    logic signed [COORD_W-1:0] ray_dir_x;
    logic signed [COORD_W-1:0] ray_dir_y;
    logic signed [COORD_W-1:0] seg_start_x;
    logic signed [COORD_W-1:0] seg_start_y;
    logic signed [COORD_W-1:0] seg_end_x;
    logic signed [COORD_W-1:0] seg_end_y;
    logic                      last_segment;

    modport source (
        output valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
               seg_start_x, seg_start_y, seg_end_x, seg_end_y, last_segment,
        input  ready
    );
    modport sink (
        input  valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
               seg_start_x, seg_start_y, seg_end_x, seg_end_y, last_segment,
        output ready
    );
endinterface

interface nrsh_hit_if import nrsh_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic                      hit_found;

    modport source (output valid, hit_x, hit_y, hit_found, input ready);
    modport sink (input valid, hit_x, hit_y, hit_found, output ready);
endinterface

/* sv/nearest_ray_segment_hit_top.sv */
`timescale 1ns / 1ps
// Nearest ray/segment hit. Each input word carries the ray and one segment;
// the block keeps the smallest ray distance t of any hit and, on the word
// marked last_segment, returns origin + dir*t (saturated) and a hit flag, then
// starts a fresh query. Words are taken one at a time. A segment whose
// parameter is exactly one skips the fraction divide; a parallel segment
// leaves after the cross products, and one whose parameter falls outside
// [0,1] after the range check. The last segment of a query goes on to the
// hit point multiply, and waits longer while an earlier result still waits
// to be taken. The multiply-accumulate units and the restoring divider are
// bit-serial and each resolve one bit per cycle. A finished result waits in
// an output register while the next segment is accepted.
// Depends on nrsh_pkg, nrsh_if, nrsh_mac and nrsh_div.

module nearest_ray_segment_hit_top import nrsh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nrsh_seg_if.sink   i_seg,
    nrsh_hit_if.source o_hit
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_SETUP = 15'b000000000000010,
        S_PROD  = 15'b000000000000100,
        S_NEG   = 15'b000000000001000,
        S_RANGE = 15'b000000000010000,
        S_UDIV  = 15'b000000000100000,
        S_NSET  = 15'b000000001000000,
        S_NUMER = 15'b000000010000000,
        S_TCHK  = 15'b000000100000000,
        S_TSAT  = 15'b000001000000000,
        S_TDIV  = 15'b000010000000000,
        S_UPD   = 15'b000100000000000,
        S_NEXT  = 15'b001000000000000,
        S_HMUL  = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } t_state;

    function automatic logic signed [COORD_W-1:0] sat_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic [COORD_W:0]          d;
        logic signed [COORD_W-1:0] res;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W:COORD_W-1] == 2'b01) begin
            res = SAT_POS;
        end else if (d[COORD_W] && (d[COORD_W-1:0] <= INT_MIN)) begin
            res = SAT_NEG;
        end else begin
            res = d[COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
        return v[COORD_W-1] ? -v : v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_out(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [COORD_W-1:0] res;
        hi = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > hi) begin
            res = INT_MAX;
        end else if (v < lo) begin
            res = INT_MIN;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    t_state r_state;
    t_state n_state;

    logic signed [COORD_W-1:0] r_rx, r_ry, r_dx, r_dy;
    logic signed [COORD_W-1:0] r_mx, r_my, r_ex, r_ey;
    logic                      r_selx;
    logic                      r_last;
    logic signed [DEN_W-1:0]   r_n;
    logic [DEN_W-1:0]          r_d;
    logic [U_W-1:0]            r_u;
    logic [MAG_W-1:0]          r_magn;
    logic [COORD_W-1:0]        r_magd;
    logic [T_W-1:0]            r_t;
    logic [T_W-1:0]            r_nearest_t;
    logic                      r_any_hit;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_hit_x;
    logic signed [COORD_W-1:0] r_hit_y;
    logic                      r_hit_found;

    t_mac_req                  w_mac0_req, w_mac1_req;
    logic signed [ACC_W-1:0]   w_mac0_init;
    logic signed [COORD_W-1:0] w_mac0_a1, w_mac0_a2, w_mac1_a1, w_mac1_a2;
    logic [MUL_W-1:0]          w_mac0_b1, w_mac0_b2, w_mac1_b1, w_mac1_b2;
    logic                      w_mac0_busy, w_mac1_busy;
    logic signed [ACC_W-1:0]   w_acc0, w_acc1;

    t_div_req                  w_div_req;
    logic [REM_W-1:0]          w_div_rem0;
    logic [T_W-1:0]            w_div_bits;
    logic [DEN_W-1:0]          w_div_divisor;
    logic                      w_div_busy;
    logic [T_W-1:0]            w_quo;

    logic                      w_accept;
    logic                      w_emit;
    logic signed [DEN_W-1:0]   w_num, w_den;
    logic                      w_u_skip, w_u_one;
    logic signed [NUMER_W-1:0] w_numer;
    logic signed [NUMER_W-1:0] w_numer_abs;
    logic signed [COORD_W-1:0] w_dsel;
    logic                      w_t_skip;
    logic                      w_tsat;
    logic signed [COORD_W-1:0] w_nex;
    logic signed [ACC_W-1:0]   w_nex_ext, w_ey_ext;
    logic signed [ACC_W-1:0]   w_qx, w_qy, w_rx_ext, w_ry_ext, w_sum_x, w_sum_y;

    assign w_accept = i_seg.valid && i_seg.ready;
    assign w_emit   = (r_state == S_EMIT) && (!r_out_valid || o_hit.ready);

    // Per-segment decisions.
    always_comb begin
        w_num    = w_acc0[DEN_W-1:0];
        w_den    = w_acc1[DEN_W-1:0];
        w_u_skip = r_n[DEN_W-1] || ($unsigned(r_n) > r_d);
        w_u_one  = ($unsigned(r_n) == r_d);

        w_numer     = w_acc0[NUMER_W-1:0];
        w_numer_abs = w_numer[NUMER_W-1] ? -w_numer : w_numer;
        w_dsel      = r_selx ? r_dx : r_dy;
        // A hit needs t >= 0: the numerator must not oppose the direction.
        w_t_skip    = (w_dsel == '0) ||
                      ((w_numer != '0) && (w_numer[NUMER_W-1] != w_dsel[COORD_W-1]));
        // The quotient reaches 2^32 exactly when the upper numerator bits
        // already reach the divisor.
        w_tsat      = ({{(T_W-FRAC_BITS){1'b0}}, r_magn[MAG_W-1:T_W]} >= r_magd);

        w_nex     = -r_ex;
        w_nex_ext = {{(ACC_W-COORD_W){w_nex[COORD_W-1]}}, w_nex};
        w_ey_ext  = {{(ACC_W-COORD_W){r_ey[COORD_W-1]}}, r_ey};

        w_qx     = w_acc0 >>> FRAC_BITS;
        w_qy     = w_acc1 >>> FRAC_BITS;
        w_rx_ext = {{(ACC_W-COORD_W){r_rx[COORD_W-1]}}, r_rx};
        w_ry_ext = {{(ACC_W-COORD_W){r_ry[COORD_W-1]}}, r_ry};
        w_sum_x  = w_qx + w_rx_ext;
        w_sum_y  = w_qy + w_ry_ext;
    end

    // Operand selection for the two multiply-accumulate units.
    always_comb begin
        w_mac0_req  = '0;
        w_mac1_req  = '0;
        w_mac0_init = '0;
        w_mac0_a1   = '0;
        w_mac0_a2   = '0;
        w_mac0_b1   = '0;
        w_mac0_b2   = '0;
        w_mac1_a1   = '0;
        w_mac1_a2   = '0;
        w_mac1_b1   = '0;
        w_mac1_b2   = '0;
        case (r_state)
            S_SETUP: begin
                // num = dx*ey + dy*ex, den = mx*dy - my*dx
                w_mac0_req = '{start: 1'b1, nbits: CNT_W'(COORD_W)};
                w_mac0_a1  = r_ey;
                w_mac0_b1  = {r_dx[COORD_W-1], r_dx};
                w_mac0_a2  = r_ex;
                w_mac0_b2  = {r_dy[COORD_W-1], r_dy};
                w_mac1_req = '{start: 1'b1, nbits: CNT_W'(COORD_W)};
                w_mac1_a1  = r_mx;
                w_mac1_b1  = {r_dy[COORD_W-1], r_dy};
                w_mac1_a2  = -r_my;
                w_mac1_b2  = {r_dx[COORD_W-1], r_dx};
            end
            S_NSET: begin
                w_mac0_req  = '{start: 1'b1, nbits: CNT_W'(U_MUL_BITS)};
                w_mac0_init = r_selx ? (w_nex_ext <<< FRAC_BITS) : (w_ey_ext <<< FRAC_BITS);
                w_mac0_a1   = r_selx ? r_mx : r_my;
                w_mac0_b1   = {{(MUL_W-U_W){1'b0}}, r_u};
            end
            S_NEXT: begin
                if (r_last) begin
                    w_mac0_req = '{start: 1'b1, nbits: CNT_W'(MUL_W)};
                    w_mac0_a1  = r_dx;
                    w_mac0_b1  = {1'b0, r_nearest_t};
                    w_mac1_req = '{start: 1'b1, nbits: CNT_W'(MUL_W)};
                    w_mac1_a1  = r_dy;
                    w_mac1_b1  = {1'b0, r_nearest_t};
                end
            end
            default: begin
            end
        endcase
    end

    // Divider operands: the fraction of u, or the distance t.
    always_comb begin
        w_div_req     = '0;
        w_div_rem0    = '0;
        w_div_bits    = '0;
        w_div_divisor = '0;
        case (r_state)
            S_RANGE: begin
                if (!w_u_skip && !w_u_one) begin
                    w_div_req     = '{start: 1'b1, steps: CNT_W'(FRAC_BITS)};
                    w_div_rem0    = {1'b0, r_n};
                    w_div_divisor = r_d;
                end
            end
            S_TSAT: begin
                if (!w_tsat) begin
                    w_div_req     = '{start: 1'b1, steps: CNT_W'(T_W)};
                    w_div_rem0    = {{(REM_W-FRAC_BITS){1'b0}}, r_magn[MAG_W-1:T_W]};
                    w_div_bits    = r_magn[T_W-1:0];
                    w_div_divisor = {{(DEN_W-COORD_W){1'b0}}, r_magd};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_SETUP;
            S_SETUP: n_state = S_PROD;
            S_PROD:  if (!w_mac0_busy && !w_mac1_busy) n_state = S_NEG;
            S_NEG:   n_state = (w_den == '0) ? S_NEXT : S_RANGE;
            S_RANGE: begin
                if (w_u_skip) begin
                    n_state = S_NEXT;
                end else if (w_u_one) begin
                    n_state = S_NSET;
                end else begin
                    n_state = S_UDIV;
                end
            end
            S_UDIV:  if (!w_div_busy) n_state = S_NSET;
            S_NSET:  n_state = S_NUMER;
            S_NUMER: if (!w_mac0_busy) n_state = S_TCHK;
            S_TCHK:  n_state = w_t_skip ? S_NEXT : S_TSAT;
            S_TSAT:  n_state = w_tsat ? S_UPD : S_TDIV;
            S_TDIV:  if (!w_div_busy) n_state = S_UPD;
            S_UPD:   n_state = S_NEXT;
            S_NEXT:  n_state = r_last ? S_HMUL : S_IDLE;
            S_HMUL:  if (!w_mac0_busy && !w_mac1_busy) n_state = S_EMIT;
            S_EMIT:  if (w_emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nearest_t <= T_MAX;
            r_any_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_nearest_t <= T_MAX;
                r_any_hit   <= 1'b0;
            end else if (r_state == S_UPD) begin
                if (r_t < r_nearest_t) begin
                    r_nearest_t <= r_t;
                end
                r_any_hit <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_hit.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rx   <= i_seg.ray_origin_x;
            r_ry   <= i_seg.ray_origin_y;
            r_dx   <= i_seg.ray_dir_x;
            r_dy   <= i_seg.ray_dir_y;
            r_mx   <= sat_diff(i_seg.seg_end_x, i_seg.seg_start_x);
            r_my   <= sat_diff(i_seg.seg_end_y, i_seg.seg_start_y);
            r_ex   <= sat_diff(i_seg.ray_origin_x, i_seg.seg_start_x);
            r_ey   <= sat_diff(i_seg.seg_start_y, i_seg.ray_origin_y);
            r_selx <= (mag(i_seg.ray_dir_x) >= mag(i_seg.ray_dir_y));
            r_last <= i_seg.last_segment;
        end
        if (r_state == S_NEG) begin
            // Fold the sign of the denominator into the numerator.
            r_n <= w_den[DEN_W-1] ? -w_num : w_num;
            r_d <= w_den[DEN_W-1] ? -w_den : w_den;
        end
        if ((r_state == S_RANGE) && w_u_one) begin
            r_u <= {1'b1, {FRAC_BITS{1'b0}}};
        end else if ((r_state == S_UDIV) && !w_div_busy) begin
            r_u <= {1'b0, w_quo[FRAC_BITS-1:0]};
        end
        if (r_state == S_TCHK) begin
            r_magn <= w_numer_abs[MAG_W-1:0];
            r_magd <= mag(w_dsel);
        end
        if ((r_state == S_TSAT) && w_tsat) begin
            r_t <= T_MAX;
        end else if ((r_state == S_TDIV) && !w_div_busy) begin
            r_t <= w_quo;
        end
        if (w_emit) begin
            r_hit_x     <= sat_out(w_sum_x);
            r_hit_y     <= sat_out(w_sum_y);
            r_hit_found <= r_any_hit;
        end
    end

    nrsh_mac u_mac0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac0_req),
        .i_init  (w_mac0_init),
        .i_a1    (w_mac0_a1),
        .i_a2    (w_mac0_a2),
        .i_b1    (w_mac0_b1),
        .i_b2    (w_mac0_b2),
        .o_busy  (w_mac0_busy),
        .o_acc   (w_acc0)
    );

    nrsh_mac u_mac1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac1_req),
        .i_init  ('0),
        .i_a1    (w_mac1_a1),
        .i_a2    (w_mac1_a2),
        .i_b1    (w_mac1_b1),
        .i_b2    (w_mac1_b2),
        .o_busy  (w_mac1_busy),
        .o_acc   (w_acc1)
    );

    nrsh_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_rem0    (w_div_rem0),
        .i_bits    (w_div_bits),
        .i_divisor (w_div_divisor),
        .o_busy    (w_div_busy),
        .o_quo     (w_quo)
    );

    assign i_seg.ready     = (r_state == S_IDLE);
    assign o_hit.valid     = r_out_valid;
    assign o_hit.hit_x     = r_hit_x;
    assign o_hit.hit_y     = r_hit_y;
    assign o_hit.hit_found = r_hit_found;

    a_mac_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mac0_req.start || w_mac1_req.start) |-> (!w_mac0_busy && !w_mac1_busy))
        else $error("multiply unit restarted while busy");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_busy)
        else $error("divider restarted while busy");

    a_no_hit_max_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any_hit |-> (r_nearest_t == T_MAX))
        else $error("nearest distance moved without a recorded hit");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SETUP))
        else $error("accepted word did not start the segment test");

endmodule

/* sv/nrsh_mac.sv */
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate: acc = init + a1*b1 + a2*b2, one multiplier
// bit per cycle, the top bit weighted negative. Depends on nrsh_pkg.

module nrsh_mac import nrsh_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_req                  i_req,
    input  logic signed [ACC_W-1:0]   i_init,
    input  logic signed [COORD_W-1:0] i_a1,
    input  logic signed [COORD_W-1:0] i_a2,
    input  logic [MUL_W-1:0]          i_b1,
    input  logic [MUL_W-1:0]          i_b2,
    output logic                      o_busy,
    output logic signed [ACC_W-1:0]   o_acc
);

    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] r_a1;
    logic signed [ACC_W-1:0] r_a2;
    logic [MUL_W-1:0]        r_b1;
    logic [MUL_W-1:0]        r_b2;
    logic signed [ACC_W-1:0] w_p1;
    logic signed [ACC_W-1:0] w_p2;
    logic                    w_last;

    always_comb begin
        w_last = (r_cnt == CNT_W'(1));
        w_p1   = r_b1[0] ? r_a1 : '0;
        w_p2   = r_b2[0] ? r_a2 : '0;
        // The sign bit of a two's complement multiplier carries weight -2^n.
        if (w_last) begin
            w_p1 = -w_p1;
            w_p2 = -w_p2;
        end
        n_acc = r_acc + w_p1 + w_p2;
        n_cnt = r_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.nbits;
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_init;
            r_a1  <= {{(ACC_W-COORD_W){i_a1[COORD_W-1]}}, i_a1};
            r_a2  <= {{(ACC_W-COORD_W){i_a2[COORD_W-1]}}, i_a2};
            r_b1  <= i_b1;
            r_b2  <= i_b2;
        end else if (r_cnt != '0) begin
            r_acc <= n_acc;
            r_a1  <= r_a1 <<< 1;
            r_a2  <= r_a2 <<< 1;
            r_b1  <= r_b1 >> 1;
            r_b2  <= r_b2 >> 1;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_acc  = r_acc;

endmodule

/* sv/nrsh_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The partial remainder starts
// below the divisor and takes one dividend bit per step. Depends on nrsh_pkg.

module nrsh_div import nrsh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    input  logic [REM_W-1:0]   i_rem0,
    input  logic [T_W-1:0]     i_bits,
    input  logic [DEN_W-1:0]   i_divisor,
    output logic               o_busy,
    output logic [T_W-1:0]     o_quo
);

    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] n_rem;
    logic [DEN_W-1:0] r_divisor;
    logic [T_W-1:0]   r_bits;
    logic [T_W-1:0]   r_quo;
    logic [REM_W-1:0] w_shift;
    logic             w_ge;

    always_comb begin
        w_shift = {r_rem[REM_W-2:0], r_bits[T_W-1]};
        w_ge    = (w_shift >= {1'b0, r_divisor});
        n_rem   = w_ge ? (w_shift - {1'b0, r_divisor}) : w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= i_rem0;
            r_bits    <= i_bits;
            r_divisor <= i_divisor;
            r_quo     <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= n_rem;
            r_bits <= r_bits << 1;
            r_quo  <= {r_quo[T_W-2:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

/* dv/tb_nearest_ray_segment_hit_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for nearest_ray_segment_hit_top: a directed table, then random
// queries, checked word by word against a fixed-point nearest-hit predictor or a typed result.
// Depends on nrsh_pkg, nrsh_if and the block itself.

module tb_nearest_ray_segment_hit_top;
    import nrsh_pkg::*;

    localparam longint ONE      = 64'sd1 << FRAC_BITS;
    localparam longint LIM31    = 64'sd2147483647;
    localparam longint TOP32    = 64'sd2147483647;
    localparam longint BOTTOM32 = -64'sd2147483648;
    localparam longint unsigned T_LIMIT = 64'hFFFF_FFFF;
    localparam int     RANDOM_WORDS = 1430;
    localparam int     LONG_HOLD    = 2500;

    typedef struct packed {
        logic signed [COORD_W-1:0] ray_origin_x;
        logic signed [COORD_W-1:0] ray_origin_y;
        logic signed [COORD_W-1:0] ray_dir_x;
        logic signed [COORD_W-1:0] ray_dir_y;
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic                      last_segment;
    } seg_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic                      hit_found;
    } hit_word_t;

    typedef struct packed {
        seg_word_t word;
        logic      typed;
        hit_word_t want;
    } probe_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nrsh_seg_if seg_ch ();
    nrsh_hit_if hit_ch ();

    nearest_ray_segment_hit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch),
        .o_hit   (hit_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: nearest ray distance so far and whether anything was hit.
    logic [T_W-1:0] closest_t    = T_MAX;
    bit             any_hit_seen = 1'b0;

    hit_word_t pending_hits [$];
    probe_t    probe_rows [$];
    int        errors    = 0;
    int        hits_seen = 0;
    bit        calm_tail = 1'b0;

    function automatic longint clip31(input longint v);
        if (v > LIM31) return LIM31;
        if (v < -LIM31) return -LIM31;
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] clip32(input longint v);
        if (v > TOP32) return INT_MAX;
        if (v < BOTTOM32) return INT_MIN;
        return v[COORD_W-1:0];
    endfunction

    // Restoring division, one quotient bit per step; num <= den and den > 0.
    function automatic longint unit_fraction(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = num;
        if (rem >= den) begin
            q   = 1;
            rem = rem - den;
        end
        for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 64'd1;
            end
        end
        return longint'(q);
    endfunction

    function automatic void cross_segment(input seg_word_t w);
        longint rx, ry, dx, dy, ax, ay, bx, by;
        longint mx, my, ey, ex, num, den, u, numer, dsel, adx, ady;
        longint unsigned mag_n, mag_d, t;
        rx = longint'($signed(w.ray_origin_x));
        ry = longint'($signed(w.ray_origin_y));
        dx = longint'($signed(w.ray_dir_x));
        dy = longint'($signed(w.ray_dir_y));
        ax = longint'($signed(w.seg_start_x));
        ay = longint'($signed(w.seg_start_y));
        bx = longint'($signed(w.seg_end_x));
        by = longint'($signed(w.seg_end_y));
        mx  = clip31(bx - ax);
        my  = clip31(by - ay);
        ey  = clip31(ay - ry);
        ex  = clip31(rx - ax);
        num = dx * ey + dy * ex;
        den = mx * dy - my * dx;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (den == 0) return;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num < 0 || num > den) return;
        u = unit_fraction(num, den);
        // The distance is solved along the larger direction component, x on a tie.
        if (adx >= ady) begin
            numer = (-ex) * ONE + mx * u;
            dsel  = dx;
        end else begin
            numer = ey * ONE + my * u;
            dsel  = dy;
        end
        if (dsel == 0) return;
        if (numer != 0 && ((numer < 0) != (dsel < 0))) return;
        mag_n = (numer < 0) ? -numer : numer;
        mag_d = (dsel < 0) ? -dsel : dsel;
        t = mag_n / mag_d;
        if (t > T_LIMIT) t = T_LIMIT;
        if (t[T_W-1:0] < closest_t) closest_t = t[T_W-1:0];
        any_hit_seen = 1'b1;
    endfunction

    // Arithmetic shift floors the scaled product toward minus infinity.
    function automatic logic signed [COORD_W-1:0] ray_point(input longint org,
                                                            input longint dir,
                                                            input logic [T_W-1:0] t);
        longint p;
        p = dir * longint'(t);
        return clip32(org + (p >>> FRAC_BITS));
    endfunction

    function automatic bit trace_word(input seg_word_t w, output hit_word_t h);
        h = '0;
        cross_segment(w);
        if (!w.last_segment) return 1'b0;
        h.hit_x      = ray_point(longint'($signed(w.ray_origin_x)),
                                 longint'($signed(w.ray_dir_x)), closest_t);
        h.hit_y      = ray_point(longint'($signed(w.ray_origin_y)),
                                 longint'($signed(w.ray_dir_y)), closest_t);
        h.hit_found  = any_hit_seen;
        closest_t    = T_MAX;
        any_hit_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_row(input longint ox, input longint oy,
                                    input longint dx, input longint dy,
                                    input longint ax, input longint ay,
                                    input longint bx, input longint by,
                                    input bit last, input bit typed = 1'b0,
                                    input longint wx = 0, input longint wy = 0,
                                    input bit wf = 1'b0);
        probe_t p;
        p.word.ray_origin_x = ox[COORD_W-1:0];
        p.word.ray_origin_y = oy[COORD_W-1:0];
        p.word.ray_dir_x    = dx[COORD_W-1:0];
        p.word.ray_dir_y    = dy[COORD_W-1:0];
        p.word.seg_start_x  = ax[COORD_W-1:0];
        p.word.seg_start_y  = ay[COORD_W-1:0];
        p.word.seg_end_x    = bx[COORD_W-1:0];
        p.word.seg_end_y    = by[COORD_W-1:0];
        p.word.last_segment = last;
        p.typed             = typed;
        p.want.hit_x        = wx[COORD_W-1:0];
        p.want.hit_y        = wy[COORD_W-1:0];
        p.want.hit_found    = wf;
        probe_rows.push_back(p);
    endfunction

    function automatic longint near(input longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic longint any_coord();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return INT_MIN;
                    1:       return INT_MAX;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            1, 2, 3: return longint'($signed($urandom()));
            default: return near(200 * ONE);
        endcase
    endfunction

    function automatic longint pick_dir();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return near(4);
            2:       return any_coord();
            default: return near(16 * ONE);
        endcase
    endfunction

    function automatic seg_word_t random_segment(input longint ox, input longint oy,
                                                 input longint dx, input longint dy);
        seg_word_t w;
        longint    ax, ay, bx, by, px, py, vx, vy, tq, k, tmp;
        // Now and then the ray moves inside a query; the block takes it from each word.
        if ($urandom_range(0, 19) == 0) begin
            ox = ox + near(ONE);
            dy = pick_dir();
        end
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                ax = any_coord();
                ay = any_coord();
                bx = any_coord();
                by = any_coord();
            end
            3: begin
                // Segment along the ray direction, so the denominator is zero.
                ax = near(100 * ONE);
                ay = near(100 * ONE);
                k  = near(3);
                bx = ax + dx * k;
                by = ay + dy * k;
            end
            default: begin
                // Segment through a point on the ray, endpoints scattered around it.
                tq = $urandom_range(0, 40 * ONE);
                px = ox + ((dx * tq) >>> FRAC_BITS);
                py = oy + ((dy * tq) >>> FRAC_BITS);
                vx = near(8 * ONE);
                vy = near(8 * ONE);
                k  = $urandom_range(0, 4 * ONE);
                ax = px + vx;
                ay = py + vy;
                bx = px - ((vx * k) >>> FRAC_BITS);
                by = py - ((vy * k) >>> FRAC_BITS);
                if ($urandom_range(0, 1) == 1) begin
                    tmp = ax; ax = bx; bx = tmp;
                    tmp = ay; ay = by; by = tmp;
                end
            end
        endcase
        w.ray_origin_x = clip32(ox);
        w.ray_origin_y = clip32(oy);
        w.ray_dir_x    = clip32(dx);
        w.ray_dir_y    = clip32(dy);
        w.seg_start_x  = clip32(ax);
        w.seg_start_y  = clip32(ay);
        w.seg_end_x    = clip32(bx);
        w.seg_end_y    = clip32(by);
        w.last_segment = 1'b0;
        return w;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 45;
        endcase
    endfunction

    task automatic offer_word(input seg_word_t w, input int idle_pct, input bit typed,
                              input hit_word_t want);
        hit_word_t h;
        if (!calm_tail && $urandom_range(0, 99) < idle_pct) begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        seg_ch.valid        <= 1'b1;
        seg_ch.ray_origin_x <= w.ray_origin_x;
        seg_ch.ray_origin_y <= w.ray_origin_y;
        seg_ch.ray_dir_x    <= w.ray_dir_x;
        seg_ch.ray_dir_y    <= w.ray_dir_y;
        seg_ch.seg_start_x  <= w.seg_start_x;
        seg_ch.seg_start_y  <= w.seg_start_y;
        seg_ch.seg_end_x    <= w.seg_end_x;
        seg_ch.seg_end_y    <= w.seg_end_y;
        seg_ch.last_segment <= w.last_segment;
        @(posedge i_clk);
        while (!seg_ch.ready) @(posedge i_clk);
        if (trace_word(w, h)) pending_hits.push_back(typed ? want : h);
    endtask

    task automatic wait_for_drain();
        seg_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_hits.size() != 0);
    endtask

    task automatic check_hit(input hit_word_t got);
        hit_word_t want;
        if (pending_hits.size() == 0) begin
            $display("%0t: unexpected hit word x=%h y=%h found=%b", $time,
                     got.hit_x, got.hit_y, got.hit_found);
            errors++;
            return;
        end
        want = pending_hits.pop_front();
        if (got.hit_x !== want.hit_x) begin
            $display("%0t: hit_x expected %h got %h", $time, want.hit_x, got.hit_x);
            errors++;
        end
        if (got.hit_y !== want.hit_y) begin
            $display("%0t: hit_y expected %h got %h", $time, want.hit_y, got.hit_y);
            errors++;
        end
        if (got.hit_found !== want.hit_found) begin
            $display("%0t: hit_found expected %b got %b", $time,
                     want.hit_found, got.hit_found);
            errors++;
        end
    endtask

    initial begin : seg_source
        seg_word_t w;
        probe_t    p;
        longint    ox, oy, dx, dy;
        int        qlen, idle_pct, random_sent;
        bit        paused_mid;
        random_sent = 0;
        paused_mid  = 1'b0;
        i_rst_n             <= 1'b0;
        seg_ch.valid        <= 1'b0;
        seg_ch.ray_origin_x <= '0;
        seg_ch.ray_origin_y <= '0;
        seg_ch.ray_dir_x    <= '0;
        seg_ch.ray_dir_y    <= '0;
        seg_ch.seg_start_x  <= '0;
        seg_ch.seg_start_y  <= '0;
        seg_ch.seg_end_x    <= '0;
        seg_ch.seg_end_y    <= '0;
        seg_ch.last_segment <= 1'b0;

        // Ray origin, direction, segment start, segment end, last, then the typed result.
        add_row(0, 0, ONE, 0, ONE, ONE, 2*ONE, ONE, 1, 1, INT_MAX, 0, 0);
        add_row(5*ONE, -3*ONE, 0, 0, ONE, -ONE, ONE, ONE, 1, 1, 5*ONE, -3*ONE, 0);
        add_row(0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE, 1, 1, 2*ONE, 0, 1);
        add_row(0, 0, ONE, 0, -2*ONE, -ONE, -2*ONE, ONE, 1, 1, INT_MAX, 0, 0);
        add_row(0, 0, ONE, 0, 2*ONE, ONE, 2*ONE, 3*ONE, 1, 1, INT_MAX, 0, 0);
        add_row(0, 0, ONE, 0, 0, -ONE, 0, ONE, 1, 1, 0, 0, 1);
        add_row(0, 0, ONE, 0, 5*ONE, -ONE, 5*ONE, ONE, 0);
        add_row(0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE, 0);
        add_row(0, 0, ONE, 0, 8*ONE, -ONE, 8*ONE, ONE, 1, 1, 2*ONE, 0, 1);
        add_row(0, 0, 0, ONE, -ONE, 3*ONE, ONE, 3*ONE, 1, 1, 0, 3*ONE, 1);
        add_row(0, 0, ONE, ONE, 2*ONE, 0, 0, 2*ONE, 1);
        add_row(0, 0, ONE, 0, 3*ONE, 0, 3*ONE, ONE, 1);
        add_row(0, 0, ONE, 0, 4*ONE, ONE, 4*ONE, 0, 1);
        add_row(0, 0, INT_MIN, 0, -2*ONE, -ONE, -2*ONE, ONE, 1, 1, -2*ONE, 0, 1);
        add_row(0, 0, 1, 0, 30000*ONE, -ONE, 30000*ONE, ONE, 1);
        add_row(INT_MAX, 0, INT_MAX, 0, 0, 0, 0, 0, 1, 1, INT_MAX, 0, 0);
        add_row(INT_MIN, 0, INT_MIN, 0, 0, 0, 0, 0, 1, 1, INT_MIN, 0, 0);
        add_row(INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, 1);
        add_row(INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, 1);
        add_row(INT_MIN, INT_MAX, INT_MAX, INT_MIN, INT_MAX, INT_MIN, INT_MIN, INT_MAX, 1);
        add_row(-ONE, ONE, INT_MAX, INT_MIN, INT_MIN, INT_MAX, INT_MAX, INT_MIN, 1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_rows[i]) begin
            p = probe_rows[i];
            offer_word(p.word, 20, p.typed, p.want);
        end
        wait_for_drain();

        while (random_sent < RANDOM_WORDS) begin
            if (!paused_mid && random_sent >= RANDOM_WORDS / 2) begin
                paused_mid = 1'b1;
                wait_for_drain();
            end
            // The closing stretch runs with no idling on either side.
            if (random_sent >= RANDOM_WORDS - 180) calm_tail = 1'b1;
            if ($urandom_range(0, 99) < 15) begin
                ox = any_coord();
                oy = any_coord();
                dx = any_coord();
                dy = any_coord();
            end else begin
                ox = near(100 * ONE);
                oy = near(100 * ONE);
                dx = pick_dir();
                dy = pick_dir();
            end
            qlen     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                   : $urandom_range(1, 6);
            idle_pct = pick_idle_pct();
            for (int k = 0; k < qlen; k++) begin
                w = random_segment(ox, oy, dx, dy);
                w.last_segment = (k == qlen - 1);
                offer_word(w, idle_pct, 1'b0, '0);
                random_sent++;
            end
        end

        wait_for_drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : hit_sink
        hit_word_t got;
        int        stall_left, stall_pct, cycle_no;
        bit        long_hold_done;
        stall_left     = 0;
        stall_pct      = 10;
        cycle_no       = 0;
        long_hold_done = 1'b0;
        hit_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hit_ch.valid && hit_ch.ready) begin
                got.hit_x     = hit_ch.hit_x;
                got.hit_y     = hit_ch.hit_y;
                got.hit_found = hit_ch.hit_found;
                check_hit(got);
                hits_seen++;
            end
            cycle_no++;
            if (cycle_no % 300 == 0) stall_pct = pick_idle_pct();
            // One long hold-off lets finished results back up into the input side.
            if (!long_hold_done && !calm_tail && hits_seen >= 60) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                hit_ch.ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 8);
                hit_ch.ready <= 1'b0;
            end else begin
                hit_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(12_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
